>>> design/kdc_pkg.sv
// Package for the key debounce and click counter block.
// Holds register indexes, reset values, widths and the structs shared by all modules.
// Depends on nothing.
package kdc_pkg;

  // Field widths
  localparam int SAMPLE_W  = 10;
  localparam int TIME_W    = 32;
  localparam int STEPS_W   = 6;
  localparam int TIMEOUT_W = 16;
  localparam int NIBBLE_W  = 4;
  localparam int CODE_W    = 8;
  localparam int KEYS_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_STEPS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_TIMEOUT_MS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THRESHOLD = 2'd2;

  // Reset values
  localparam logic [STEPS_W-1:0]   RESET_FILTER_STEPS = 6'd30;
  localparam logic [TIMEOUT_W-1:0] RESET_TIMEOUT_MS   = 16'd500;
  localparam logic [SAMPLE_W-1:0]  RESET_THRESHOLD    = 10'd1;
  localparam logic [SAMPLE_W-1:0]  FULL_SCALE         = 10'd1023;
  localparam logic [STEPS_W-1:0]   RESET_FILTER_COUNT = 6'd1;

  // Live configuration
  typedef struct packed {
    logic [STEPS_W-1:0]   filter_steps;
    logic [TIMEOUT_W-1:0] click_timeout_ms;
    logic [SAMPLE_W-1:0]  release_threshold;
  } cfg_t;

  // Key state after one sample, handed to the click tracker
  typedef struct packed {
    logic                push;
    logic [NIBBLE_W-1:0] keys;
  } key_evt_t;

endpackage

>>> design/kdc_in_if.sv
// Input channel of the key debounce block: one ADC conversion and its timestamp.
// Depends on kdc_pkg.
interface kdc_in_if
  import kdc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, output sample, output now_ms, input ready);
  modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

>>> design/kdc_out_if.sv
// Result channel of the key debounce block: key bitmap, event and sensor value.
// Depends on kdc_pkg.
interface kdc_out_if
  import kdc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                channel;
  logic [KEYS_W-1:0]   keys_down;
  logic                event_valid;
  logic [CODE_W-1:0]   event_code;
  logic [SAMPLE_W-1:0] sensor_value;

  modport source (output valid, output channel, output keys_down, output event_valid,
                  output event_code, output sensor_value, input ready);
  modport sink   (input valid, input channel, input keys_down, input event_valid,
                  input event_code, input sensor_value, output ready);
endinterface

>>> design/kdc_chan.sv
// Per-channel state: round-robin channel pointer, sensor sample window,
// integrating debounce counters and the debounced key bits. Depends on kdc_pkg.
module kdc_chan
  import kdc_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [SAMPLE_W-1:0] sample,
  input  cfg_t                cfg,
  output logic                channel,
  output logic [SAMPLE_W-1:0] sensor_value,
  output key_evt_t            key_evt
);
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  logic [CH_W-1:0]     next_channel;
  logic [CHANNELS-1:0] key_down_bits;
  logic [STEPS_W-1:0]  filter_count [CHANNELS];
  logic [SAMPLE_W-1:0] older_sample [CHANNELS];
  logic [SAMPLE_W-1:0] newer_sample [CHANNELS];
  logic [SAMPLE_W-1:0] held_sensor  [CHANNELS];

  logic [CH_W-1:0]     ch;
  logic [SAMPLE_W-1:0] p0;
  logic [SAMPLE_W-1:0] p1;
  logic                window_ok;
  logic                released;
  logic                down;
  logic [STEPS_W:0]    cnt;
  logic [STEPS_W:0]    cnt_adj;
  logic                toggle;
  logic [CHANNELS-1:0] key_bit;
  logic [CHANNELS-1:0] key_down_bits_next;
  logic [STEPS_W-1:0]  filter_count_next;

  // Sensor window and debounce counter for the current channel
  always_comb begin
    ch        = next_channel;
    p0        = older_sample[ch];
    p1        = newer_sample[ch];
    window_ok = (p0 > cfg.release_threshold) && (p1 > cfg.release_threshold) &&
                (sample > cfg.release_threshold);
    released  = sample > cfg.release_threshold;
    down      = key_down_bits[ch];
    cnt       = {1'b0, filter_count[ch]};
    if (released == down) begin
      cnt_adj = cnt + 1'b1;
    end else if (cnt != '0) begin
      cnt_adj = cnt - 1'b1;
    end else begin
      cnt_adj = '0;
    end
    toggle  = cnt_adj >= {1'b0, cfg.filter_steps};
    key_bit = CHANNELS'(1) << ch;
    key_down_bits_next = toggle ? (key_down_bits ^ key_bit) : key_down_bits;
    filter_count_next  = toggle ? '0 : cnt_adj[STEPS_W-1:0];
  end

  // Results for this transaction
  always_comb begin
    channel       = ch[0];
    sensor_value  = window_ok ? p1 : held_sensor[ch];
    key_evt.push  = toggle && (key_down_bits == '0);
    key_evt.keys  = NIBBLE_W'(key_down_bits_next);
  end

  // Advance channel state on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      next_channel  <= '0;
      key_down_bits <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        filter_count[i] <= RESET_FILTER_COUNT;
        older_sample[i] <= FULL_SCALE;
        newer_sample[i] <= FULL_SCALE;
        held_sensor[i]  <= FULL_SCALE;
      end
    end else if (step) begin
      next_channel     <= (ch == LAST_CH) ? '0 : ch + 1'b1;
      key_down_bits    <= key_down_bits_next;
      filter_count[ch] <= filter_count_next;
      older_sample[ch] <= p1;
      newer_sample[ch] <= sample;
      if (window_ok) begin
        held_sensor[ch] <= p1;
      end
    end
  end

endmodule

>>> design/kdc_click.sv
// Click run tracker: counts pushes of the same key set and reports the run
// after a quiet timeout. Depends on kdc_pkg.
module kdc_click
  import kdc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [TIME_W-1:0] now_ms,
  input  cfg_t              cfg,
  input  key_evt_t          key_evt,
  output logic              event_valid,
  output logic [CODE_W-1:0] event_code
);
  logic [NIBBLE_W-1:0] click_keys;
  logic [NIBBLE_W-1:0] click_count;
  logic [TIME_W-1:0]   click_time;

  logic [NIBBLE_W-1:0] keys_mid;
  logic [NIBBLE_W-1:0] count_mid;
  logic [TIME_W-1:0]   time_mid;
  logic [TIME_W-1:0]   elapsed;
  logic                fire;

  // Extend or restart the run on a push from all released
  always_comb begin
    keys_mid  = click_keys;
    count_mid = click_count;
    time_mid  = click_time;
    if (key_evt.push) begin
      time_mid = now_ms;
      if (click_keys == key_evt.keys) begin
        count_mid = click_count + 1'b1;
      end else begin
        keys_mid  = key_evt.keys;
        count_mid = NIBBLE_W'(1);
      end
    end
  end

  // Report the run once the quiet time has passed; a push is reported as well
  always_comb begin
    elapsed     = now_ms - time_mid;
    fire        = (keys_mid != '0) && (elapsed >= TIME_W'(cfg.click_timeout_ms));
    event_valid = key_evt.push || fire;
    if (fire) begin
      event_code = {count_mid, keys_mid};
    end else if (key_evt.push) begin
      event_code = {{NIBBLE_W{1'b0}}, key_evt.keys};
    end else begin
      event_code = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      click_keys  <= '0;
      click_count <= '0;
      click_time  <= '0;
    end else if (step) begin
      click_keys  <= fire ? '0 : keys_mid;
      click_count <= fire ? '0 : count_mid;
      click_time  <= time_mid;
    end
  end

endmodule

>>> design/key_debounce_click_counter.sv
// Top level of the key debounce and click counter block.
// Depends on kdc_pkg, kdc_in_if, kdc_out_if, kdc_chan and kdc_click.
//
//   channel   role    payload
//   samples   sink    sample[9:0], now_ms[31:0]
//   results   source  channel, keys_down[1:0], event_valid, event_code[7:0],
//                     sensor_value[9:0]
//   cfg_*     write   cfg_index[1:0], cfg_data[15:0]
//
// One transaction per cycle sustained while results are taken. A sample is
// captured in the input register, processed combinationally against the channel
// and click state, and lands in the result register.
// Result back-pressure holds the input register; samples.ready stays high
// whenever the result register drains or is empty.
// Synchronous reset clears the valid flags, resets channel and click state and loads default register values.
module key_debounce_click_counter
  import kdc_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  kdc_in_if.sink                samples,
  kdc_out_if.source             results
);
  cfg_t cfg;

  // Input register
  logic                s_valid;
  logic [SAMPLE_W-1:0] s_sample;
  logic [TIME_W-1:0]   s_now_ms;

  // Result register
  logic                r_valid;
  logic                r_channel;
  logic [KEYS_W-1:0]   r_keys_down;
  logic                r_event_valid;
  logic [CODE_W-1:0]   r_event_code;
  logic [SAMPLE_W-1:0] r_sensor_value;

  logic                step;
  logic                c_channel;
  logic [SAMPLE_W-1:0] c_sensor_value;
  key_evt_t            key_evt;
  logic                c_event_valid;
  logic [CODE_W-1:0]   c_event_code;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_steps      <= RESET_FILTER_STEPS;
      cfg.click_timeout_ms  <= RESET_TIMEOUT_MS;
      cfg.release_threshold <= RESET_THRESHOLD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FILTER_STEPS:      cfg.filter_steps      <= cfg_data[STEPS_W-1:0];
        REG_CLICK_TIMEOUT_MS:  cfg.click_timeout_ms  <= cfg_data[TIMEOUT_W-1:0];
        REG_RELEASE_THRESHOLD: cfg.release_threshold <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance when the input register is full and the result register frees up
  assign step          = s_valid && (!r_valid || results.ready);
  assign samples.ready = !s_valid || step;

  // Capture input transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (samples.ready) begin
      s_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s_sample <= samples.sample;
      s_now_ms <= samples.now_ms;
    end
  end

  kdc_chan #(
    .CHANNELS(CHANNELS)
  ) u_chan (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .sample       (s_sample),
    .cfg          (cfg),
    .channel      (c_channel),
    .sensor_value (c_sensor_value),
    .key_evt      (key_evt)
  );

  kdc_click u_click (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .now_ms      (s_now_ms),
    .cfg         (cfg),
    .key_evt     (key_evt),
    .event_valid (c_event_valid),
    .event_code  (c_event_code)
  );

  // Hold results until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (step) begin
      r_valid <= 1'b1;
    end else if (results.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      r_channel      <= c_channel;
      r_keys_down    <= key_evt.keys[KEYS_W-1:0];
      r_event_valid  <= c_event_valid;
      r_event_code   <= c_event_code;
      r_sensor_value <= c_sensor_value;
    end
  end

  assign results.valid        = r_valid;
  assign results.channel      = r_channel;
  assign results.keys_down    = r_keys_down;
  assign results.event_valid  = r_event_valid;
  assign results.event_code   = r_event_code;
  assign results.sensor_value = r_sensor_value;

endmodule

>>> tb/key_debounce_click_counter_tb.sv
// Testbench for key_debounce_click_counter: a directed table, then random key gestures
// under several register settings and idle patterns, checked against a built-in model.
// Depends on kdc_pkg, kdc_in_if, kdc_out_if and the block itself.
module key_debounce_click_counter_tb;
  import kdc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 60;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic                channel;
    logic [KEYS_W-1:0]   keys_down;
    logic                event_valid;
    logic [CODE_W-1:0]   event_code;
    logic [SAMPLE_W-1:0] sensor_value;
  } click_report_t;

  // Item rows carry the timestamp in arg, register rows the write data
  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [TIME_W-1:0]    arg;
    logic [SAMPLE_W-1:0]  sample;
    logic                 typed;
    click_report_t        want;
  } directed_row_t;

  typedef struct packed {
    logic [STEPS_W-1:0]   steps;
    logic [TIMEOUT_W-1:0] timeout;
    logic [SAMPLE_W-1:0]  thresh;
  } phase_cfg_t;

  directed_row_t directed_rows [34] = '{
    // straight after reset: nothing pressed, sensors at full scale
    '{ROW_ITEM, '0, 32'd0, 10'd1023, 1'b1, '{1'b0, 2'b00, 1'b0, 8'h00, FULL_SCALE}},
    '{ROW_ITEM, '0, 32'd1, 10'd0, 1'b1, '{1'b1, 2'b00, 1'b0, 8'h00, FULL_SCALE}},
    '{ROW_ITEM, '0, 32'd2, 10'd512, 1'b1, '{1'b0, 2'b00, 1'b0, 8'h00, FULL_SCALE}},
    '{ROW_ITEM, '0, 32'd3, 10'd1, 1'b1, '{1'b1, 2'b00, 1'b0, 8'h00, FULL_SCALE}},
    // single-step filter and short timeout: first press on channel 0 reports a push
    '{ROW_CFG, REG_FILTER_STEPS, 32'd1, 10'd0, 1'b0, '0},
    '{ROW_CFG, REG_CLICK_TIMEOUT_MS, 32'd5, 10'd0, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd10, 10'd0, 1'b1, '{1'b0, 2'b01, 1'b1, 8'h01, FULL_SCALE}},
    '{ROW_ITEM, '0, 32'd11, 10'd1023, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd12, 10'd1023, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd13, 10'd0, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd14, 10'd0, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd15, 10'd1023, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd30, 10'd1023, 1'b0, '0},
    // zero filter limit and zero timeout: toggle every sample, push and report together
    '{ROW_CFG, REG_FILTER_STEPS, 32'd0, 10'd0, 1'b0, '0},
    '{ROW_CFG, REG_CLICK_TIMEOUT_MS, 32'd0, 10'd0, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd100, 10'd0, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd101, 10'd1023, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd102, 10'd0, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd103, 10'd1023, 1'b0, '0},
    // click run across the timestamp wrap
    '{ROW_CFG, REG_FILTER_STEPS, 32'd1, 10'd0, 1'b0, '0},
    '{ROW_CFG, REG_CLICK_TIMEOUT_MS, 32'd3, 10'd0, 1'b0, '0},
    '{ROW_ITEM, '0, 32'hFFFF_FFFE, 10'd0, 1'b0, '0},
    '{ROW_ITEM, '0, 32'hFFFF_FFFF, 10'd1023, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd0, 10'd1023, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd1, 10'd1023, 1'b0, '0},
    // full-scale threshold, write to an unmapped index, widest limit and timeout
    '{ROW_CFG, REG_RELEASE_THRESHOLD, 32'd1023, 10'd0, 1'b0, '0},
    '{ROW_CFG, REG_UNUSED, 32'hFFFF, 10'd0, 1'b0, '0},
    '{ROW_CFG, REG_FILTER_STEPS, 32'd63, 10'd0, 1'b0, '0},
    '{ROW_CFG, REG_CLICK_TIMEOUT_MS, 32'd65535, 10'd0, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd5, 10'd1023, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd6, 10'd1023, 1'b0, '0},
    '{ROW_CFG, REG_RELEASE_THRESHOLD, 32'd0, 10'd0, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd7, 10'd0, 1'b0, '0},
    '{ROW_ITEM, '0, 32'd8, 10'd1023, 1'b0, '0}
  };

  // Fixed settings first; the last phase is drawn at run time
  phase_cfg_t phase_plan [PHASES] = '{
    '{6'd30, 16'd500, 10'd1},
    '{6'd1, 16'd1, 10'd0},
    '{6'd63, 16'd65535, 10'd1022},
    '{6'd0, 16'd0, 10'd512},
    '{6'd2, 16'd1000, 10'd300},
    '{6'd4, 16'd20, 10'd1023}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  kdc_in_if  samples_if ();
  kdc_out_if results_if ();

  key_debounce_click_counter uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_if),
    .results   (results_if)
  );

  always #1 clk = ~clk;

  // Model state and register copy
  logic [STEPS_W-1:0]   cfg_steps;
  logic [TIMEOUT_W-1:0] cfg_timeout;
  logic [SAMPLE_W-1:0]  cfg_thresh;
  logic                 chan_next;
  logic [KEYS_W-1:0]    keys_now;
  logic [STEPS_W-1:0]   integ_count [2];
  logic [KEYS_W-1:0]    run_keys;
  logic [NIBBLE_W-1:0]  run_clicks;
  logic [TIME_W-1:0]    run_start_ms;
  logic [SAMPLE_W-1:0]  hist_old [2];
  logic [SAMPLE_W-1:0]  hist_new [2];
  logic [SAMPLE_W-1:0]  sensor_hold [2];

  click_report_t pending_reports [$];
  click_report_t row_expect;
  logic          row_typed = 1'b0;
  logic [TIME_W-1:0] gen_ms;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int event_count = 0;
  int mismatch_count = 0;

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch on result %0d: %s", $time, checked_count, what);
    mismatch_count++;
  endtask

  // Advance the model by one sample and return the report it produces
  task automatic debounce_step(input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] now,
                               output click_report_t r);
    logic                ch;
    logic [KEYS_W-1:0]   bitm;
    logic [KEYS_W-1:0]   prior;
    logic [SAMPLE_W-1:0] p0;
    logic [SAMPLE_W-1:0] p1;
    logic                released;
    logic                down;
    logic [STEPS_W:0]    cnt;
    logic                ev;
    logic [CODE_W-1:0]   code;
    ch = chan_next;
    bitm = 2'b01 << ch;
    ev = 1'b0;
    code = '0;
    // sensor: take the middle sample once three in a row clear the threshold
    p0 = hist_old[ch];
    p1 = hist_new[ch];
    hist_old[ch] = p1;
    hist_new[ch] = smp;
    if (p0 > cfg_thresh && p1 > cfg_thresh && smp > cfg_thresh)
      sensor_hold[ch] = p1;
    // integrate disagreement, toggle the key at the limit
    released = smp > cfg_thresh;
    down = |(keys_now & bitm);
    cnt = {1'b0, integ_count[ch]};
    if (released == down)
      cnt = cnt + 1'b1;
    else if (cnt != 0)
      cnt = cnt - 1'b1;
    if (cnt >= {1'b0, cfg_steps}) begin
      prior = keys_now;
      keys_now = keys_now ^ bitm;
      cnt = '0;
      if (prior == '0) begin
        ev = 1'b1;
        code = {6'd0, keys_now};
        if (run_keys == keys_now) begin
          run_clicks = run_clicks + 1'b1;
        end else begin
          run_keys = keys_now;
          run_clicks = 4'd1;
        end
        run_start_ms = now;
      end
    end
    integ_count[ch] = cnt[STEPS_W-1:0];
    // close the click run after the quiet time
    if (run_keys != '0 && (now - run_start_ms) >= {16'd0, cfg_timeout}) begin
      ev = 1'b1;
      code = {run_clicks, 2'b00, run_keys};
      run_keys = '0;
      run_clicks = '0;
    end
    chan_next = ~ch;
    r = '{ch, keys_now, ev, code, sensor_hold[ch]};
  endtask

  // Predict on every input transaction, check every output transaction
  always @(posedge clk) begin : scoreboard
    click_report_t predicted;
    click_report_t seen;
    click_report_t want;
    if (!rst) begin
      if (samples_if.valid && samples_if.ready) begin
        debounce_step(samples_if.sample, samples_if.now_ms, predicted);
        pending_reports.push_back(row_typed ? row_expect : predicted);
        accepted_count++;
      end
      if (results_if.valid && results_if.ready) begin
        seen = '{results_if.channel, results_if.keys_down, results_if.event_valid,
                 results_if.event_code, results_if.sensor_value};
        if (seen.event_valid === 1'b1)
          event_count++;
        if (pending_reports.size() == 0) begin
          flag_mismatch("result arrived with nothing pending");
        end else begin
          want = pending_reports.pop_front();
          if (seen.channel !== want.channel)
            flag_mismatch($sformatf("channel %0d, want %0d", seen.channel, want.channel));
          if (seen.keys_down !== want.keys_down)
            flag_mismatch($sformatf("keys_down %b, want %b", seen.keys_down, want.keys_down));
          if (seen.event_valid !== want.event_valid)
            flag_mismatch($sformatf("event_valid %b, want %b",
                                    seen.event_valid, want.event_valid));
          if (seen.event_code !== want.event_code)
            flag_mismatch($sformatf("event_code %h, want %h", seen.event_code, want.event_code));
          if (seen.sensor_value !== want.sensor_value)
            flag_mismatch($sformatf("sensor_value %0d, want %0d",
                                    seen.sensor_value, want.sensor_value));
        end
        checked_count++;
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk)
    results_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  // Offer one sample, idling first at random; return at the negedge after acceptance
  task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      samples_if.valid <= 1'b0;
      @(negedge clk);
    end
    samples_if.valid <= 1'b1;
    samples_if.sample <= smp;
    samples_if.now_ms <= now;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one register once the block has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    samples_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_FILTER_STEPS:      cfg_steps = val[STEPS_W-1:0];
      REG_CLICK_TIMEOUT_MS:  cfg_timeout = val;
      REG_RELEASE_THRESHOLD: cfg_thresh = val[SAMPLE_W-1:0];
      default: ;
    endcase
  endtask

  // Pick a conversion on the pressed or released side of the threshold
  function automatic logic [SAMPLE_W-1:0] level_sample(input bit pressed);
    if (pressed || cfg_thresh == FULL_SCALE)
      return SAMPLE_W'($urandom_range(0, cfg_thresh));
    return SAMPLE_W'($urandom_range(cfg_thresh + 1, 1023));
  endfunction

  // Send one level with occasional contact bounce, then advance the timestamp
  task automatic send_level(input bit pressed);
    send_item(level_sample(pressed ^ ($urandom_range(0, 9) == 0)), gen_ms);
    gen_ms += $urandom_range(0, 2);
  endtask

  initial begin : stimulus
    int         k;
    int         phase_start;
    int         clicks;
    int         hold;
    bit         first;
    logic [1:0] mask;
    phase_cfg_t pc;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    samples_if.valid = 1'b0;
    samples_if.sample = '0;
    samples_if.now_ms = '0;
    cfg_steps = RESET_FILTER_STEPS;
    cfg_timeout = RESET_TIMEOUT_MS;
    cfg_thresh = RESET_THRESHOLD;
    chan_next = 1'b0;
    keys_now = '0;
    run_keys = '0;
    run_clicks = '0;
    run_start_ms = '0;
    for (k = 0; k < 2; k++) begin
      integ_count[k] = RESET_FILTER_COUNT;
      hist_old[k] = FULL_SCALE;
      hist_new[k] = FULL_SCALE;
      sensor_hold[k] = FULL_SCALE;
    end
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].idx, directed_rows[i].arg[CFG_DATA_W-1:0]);
      end else begin
        row_typed = directed_rows[i].typed;
        row_expect = directed_rows[i].want;
        send_item(directed_rows[i].sample, directed_rows[i].arg);
      end
    end
    row_typed = 1'b0;

    // Random gestures, one register setting and idle pattern per phase
    for (k = 0; k < PHASES; k++) begin
      pc = phase_plan[k];
      if (k >= 5) begin
        pc.steps = STEPS_W'($urandom_range(1, 6));
        pc.timeout = TIMEOUT_W'($urandom_range(200, 2000));
        pc.thresh = SAMPLE_W'($urandom_range(0, 1022));
      end
      write_reg(REG_FILTER_STEPS, CFG_DATA_W'(pc.steps));
      write_reg(REG_CLICK_TIMEOUT_MS, pc.timeout);
      write_reg(REG_RELEASE_THRESHOLD, CFG_DATA_W'(pc.thresh));
      case (k % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      gen_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
      phase_start = accepted_count;
      first = 1'b1;
      while (accepted_count - phase_start < PHASE_ITEMS) begin
        if (!first && $urandom_range(0, 4) == 0) begin
          // raw noise burst
          repeat ($urandom_range(1, 10)) begin
            send_item(SAMPLE_W'($urandom_range(0, 1023)), gen_ms);
            gen_ms += $urandom_range(0, 40);
          end
        end else begin
          // click run: press and release a key set, then go quiet
          mask = 2'($urandom_range(1, 3));
          if (first && cfg_steps <= 2 && cfg_timeout >= 500)
            clicks = 17;
          else if (cfg_steps > 8)
            clicks = 1;
          else
            clicks = $urandom_range(1, 4);
          hold = 2 * cfg_steps + $urandom_range(2, 6);
          repeat (clicks) begin
            repeat (hold) send_level(mask[chan_next]);
            repeat (hold) send_level(1'b0);
          end
          if ($urandom_range(0, 3) == 0)
            gen_ms += $urandom_range(0, cfg_timeout);
          else
            gen_ms += cfg_timeout + $urandom_range(0, 3);
          repeat (2) send_level(1'b0);
        end
        first = 1'b0;
      end
    end

    // Drain and let the pipeline settle
    samples_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("Ran %0d samples: directed table plus %0d register settings, %0d events seen.",
             accepted_count, PHASES, event_count);
    $display("Idle patterns: none, sender gaps, result stalls, both; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d results outstanding", pending_reports.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
